// ===== sv/battery_charger_poll_scheduler_assert.svh =====
// Assertion macros used by the scheduler RTL.
`ifndef BATTERY_CHARGER_POLL_SCHEDULER_ASSERT_SVH
`define BATTERY_CHARGER_POLL_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/bcps_pkg.sv =====
`default_nettype none
package bcps_pkg;

  localparam int TimeW = 32;
  localparam int VoltW = 16;
  localparam int CodeW = 8;
  localparam int PctW  = 7;
  localparam int CntW  = 5;
  localparam int StepW = 3;
  localparam int NumW  = VoltW + PctW;

  localparam logic [CodeW-1:0] FaultMask = 8'hF0;
  localparam logic [CodeW-1:0] LowMask   = 8'h0F;
  localparam logic [PctW-1:0]  FullPct   = 7'd100;

  localparam logic [TimeW-1:0] IntervalReset = 32'd1000;
  localparam logic [CodeW-1:0] ChargingReset = 8'd1;
  localparam logic [CodeW-1:0] ConnectReset  = 8'd2;

  typedef struct packed {
    logic [TimeW-1:0] time_now;
    logic [VoltW-1:0] battery_sample;
    logic [CodeW-1:0] charger_code;
    logic             docking;
    logic             clear_fault;
  } in_t;

  typedef struct packed {
    logic             battery_polled;
    logic [PctW-1:0]  battery_percent;
    logic [VoltW-1:0] peak_voltage;
    logic             charger_polled;
    logic [CodeW-1:0] charger_status;
    logic             fault_flag;
    logic             go_charging;
    logic             watchdog_kick;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DIV_DONE
  } state_t;

  typedef enum logic [2:0] {
    REG_BAT_EN   = 3'd0,
    REG_BAT_INTV = 3'd1,
    REG_CHG_EN   = 3'd2,
    REG_CHG_INTV = 3'd3,
    REG_WD_INTV  = 3'd4,
    REG_EMPTY    = 3'd5,
    REG_CODE_CHG = 3'd6,
    REG_CODE_CON = 3'd7
  } reg_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] dividend;
    logic [VoltW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [PctW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/bcps_div.sv =====
`default_nettype none
module bcps_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bcps_pkg::div_req_t  req,
  output bcps_pkg::div_rsp_t       rsp
);

  logic [bcps_pkg::NumW-1:0]  rem;
  logic [bcps_pkg::NumW-1:0]  dsr;
  logic [bcps_pkg::PctW-1:0]  quo;
  logic [bcps_pkg::StepW-1:0] step;
  logic                       busy;
  logic                       done;
  logic [bcps_pkg::NumW:0]    diff;

  // restoring step: one quotient bit per cycle, MSB first
  assign diff = {1'b0, rem} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= bcps_pkg::StepW'(bcps_pkg::PctW - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      dsr <= bcps_pkg::NumW'({req.divisor, {(bcps_pkg::PctW - 1){1'b0}}});
      quo <= '0;
    end else if (busy) begin
      if (!diff[bcps_pkg::NumW]) begin
        rem <= diff[bcps_pkg::NumW-1:0];
      end
      quo <= {quo[bcps_pkg::PctW-2:0], ~diff[bcps_pkg::NumW]};
      dsr <= dsr >> 1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// ===== sv/battery_charger_poll_scheduler.sv =====
// A request passes the bit-serial scan, ST_CALC and ST_DIV_DONE; a battery poll
// that needs the percentage division (7 quotient bits, one per cycle) also waits
// there for the divider. Timer compares and next-deadline sums run bit-serially.
// A new request is accepted only after the previous result is registered.
// Reset (rst, synchronous, active high): registers to documented defaults,
// timers, peak, status and fault cleared, no result pending.
`default_nettype none
`include "battery_charger_poll_scheduler_assert.svh"
module battery_charger_poll_scheduler (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bcps_pkg::in_t      in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bcps_pkg::out_t          out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int TimeW = bcps_pkg::TimeW;
  localparam int VoltW = bcps_pkg::VoltW;
  localparam int CodeW = bcps_pkg::CodeW;
  localparam int PctW  = bcps_pkg::PctW;
  localparam int NumW  = bcps_pkg::NumW;

  // configuration
  logic             bat_en;
  logic [TimeW-1:0] bat_intv;
  logic             chg_en;
  logic [TimeW-1:0] chg_intv;
  logic [TimeW-1:0] wd_intv;
  logic [VoltW-1:0] empty_v;
  logic [CodeW-1:0] code_chg;
  logic [CodeW-1:0] code_con;

  // architectural state
  logic [TimeW-1:0] bat_dl;
  logic [TimeW-1:0] chg_dl;
  logic [TimeW-1:0] wd_dl;
  logic [VoltW-1:0] max_v;
  logic [PctW-1:0]  last_pct;
  logic [CodeW-1:0] last_stat;
  logic             sticky;

  // per-request work registers
  bcps_pkg::state_t      state;
  bcps_pkg::state_t      state_next;
  logic [bcps_pkg::CntW-1:0] cnt;
  bcps_pkg::in_t         item;
  logic [TimeW-1:0]      now_sh;
  logic [TimeW-1:0]      bat_sum;
  logic [TimeW-1:0]      chg_sum;
  logic [TimeW-1:0]      wd_sum;
  logic                  bat_c, chg_c, wd_c;
  logic                  bat_le, chg_le, wd_le;
  logic                  gt, lt, bm;
  logic [VoltW-1:0]      num_sh;
  logic [VoltW-1:0]      spm_sh;
  logic [PctW-1:0]       pct_new;

  bcps_pkg::div_req_t    div_req;
  bcps_pkg::div_rsp_t    div_rsp;

  logic                  cfg_wr;
  logic                  accept;
  logic                  commit;
  logic                  pct_new_ok;
  logic                  div_wait;

  // serial bit slices
  logic n_b, s_b, m_b, e_b;
  logic bd_b, cd_b, wdd_b, bi_b, ci_b, wi_b;

  logic             bat_fire, chg_fire, wd_fire;
  logic [VoltW-1:0] new_max;
  logic [VoltW-1:0] span;
  logic [CodeW-1:0] code_m;
  logic             is_fault;
  logic             fault_base;
  logic             go;
  bcps_pkg::out_t   res;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign in_ready = (state == bcps_pkg::ST_IDLE);
  assign accept = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bat_en   <= 1'b0;
      bat_intv <= bcps_pkg::IntervalReset;
      chg_en   <= 1'b0;
      chg_intv <= bcps_pkg::IntervalReset;
      wd_intv  <= bcps_pkg::IntervalReset;
      empty_v  <= '0;
      code_chg <= bcps_pkg::ChargingReset;
      code_con <= bcps_pkg::ConnectReset;
    end else if (cfg_wr) begin
      unique case (bcps_pkg::reg_t'(paddr[4:2]))
        bcps_pkg::REG_BAT_EN:   bat_en   <= pwdata[0];
        bcps_pkg::REG_BAT_INTV: bat_intv <= pwdata;
        bcps_pkg::REG_CHG_EN:   chg_en   <= pwdata[0];
        bcps_pkg::REG_CHG_INTV: chg_intv <= pwdata;
        bcps_pkg::REG_WD_INTV:  wd_intv  <= pwdata;
        bcps_pkg::REG_EMPTY:    empty_v  <= pwdata[VoltW-1:0];
        bcps_pkg::REG_CODE_CHG: code_chg <= pwdata[CodeW-1:0];
        bcps_pkg::REG_CODE_CON: code_con <= pwdata[CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bcps_pkg::reg_t'(paddr[4:2]))
      bcps_pkg::REG_BAT_EN:   prdata = {31'b0, bat_en};
      bcps_pkg::REG_BAT_INTV: prdata = bat_intv;
      bcps_pkg::REG_CHG_EN:   prdata = {31'b0, chg_en};
      bcps_pkg::REG_CHG_INTV: prdata = chg_intv;
      bcps_pkg::REG_WD_INTV:  prdata = wd_intv;
      bcps_pkg::REG_EMPTY:    prdata = 32'(empty_v);
      bcps_pkg::REG_CODE_CHG: prdata = 32'(code_chg);
      bcps_pkg::REG_CODE_CON: prdata = 32'(code_con);
      default:                prdata = '0;
    endcase
  end

  assign n_b   = now_sh[0];
  assign bd_b  = bat_dl[cnt];
  assign cd_b  = chg_dl[cnt];
  assign wdd_b = wd_dl[cnt];
  assign bi_b  = bat_intv[cnt];
  assign ci_b  = chg_intv[cnt];
  assign wi_b  = wd_intv[cnt];
  assign s_b   = item.battery_sample[cnt[3:0]];
  assign m_b   = max_v[cnt[3:0]];
  assign e_b   = empty_v[cnt[3:0]];

  assign bat_fire = bat_en & bat_le;
  assign chg_fire = chg_en & chg_le;
  assign wd_fire  = chg_en & wd_le;
  assign new_max  = gt ? item.battery_sample : max_v;
  // lt doubles as the borrow of sample - empty
  assign span     = gt ? num_sh : spm_sh;

  assign code_m     = ((item.charger_code & bcps_pkg::FaultMask) == bcps_pkg::FaultMask) ?
                      (item.charger_code & bcps_pkg::LowMask) : item.charger_code;
  assign is_fault   = ((item.charger_code & bcps_pkg::FaultMask) == bcps_pkg::FaultMask);
  assign fault_base = item.clear_fault ? 1'b0 : sticky;
  assign go         = chg_fire & ((code_m == code_chg) | (code_m == code_con)) & ~item.docking;

  always_comb begin
    res.battery_polled  = bat_fire;
    res.battery_percent = bat_fire ? pct_new : last_pct;
    res.peak_voltage    = bat_fire ? new_max : max_v;
    res.charger_polled  = chg_fire;
    res.charger_status  = chg_fire ? code_m : last_stat;
    res.fault_flag      = fault_base | (chg_fire & is_fault);
    res.go_charging     = go;
    res.watchdog_kick   = wd_fire;
  end

  assign commit = (state == bcps_pkg::ST_DIV_DONE) && (pct_new_ok) && (!out_valid || out_ready);

  // pct_new_ok: division finished or not needed
  assign pct_new_ok = ~div_wait;

  always_comb begin
    state_next = state;
    div_req.start    = 1'b0;
    div_req.dividend = NumW'(num_sh) * NumW'(bcps_pkg::FullPct);
    div_req.divisor  = span;
    unique case (state)
      bcps_pkg::ST_IDLE: begin
        if (accept) state_next = bcps_pkg::ST_SCAN;
      end
      bcps_pkg::ST_SCAN: begin
        if (cnt == '1) state_next = bcps_pkg::ST_CALC;
      end
      bcps_pkg::ST_CALC: begin
        div_req.start = bat_fire & ~lt & (span != '0);
        state_next = bcps_pkg::ST_DIV_DONE;
      end
      bcps_pkg::ST_DIV_DONE: begin
        if (commit) state_next = bcps_pkg::ST_IDLE;
      end
      default: state_next = bcps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bcps_pkg::ST_IDLE;
      div_wait <= 1'b0;
    end else begin
      state <= state_next;
      if (div_req.start) begin
        div_wait <= 1'b1;
      end else if (div_rsp.done) begin
        div_wait <= 1'b0;
      end
    end
  end

  // serial scan: LSB first, one bit per compare and sum per cycle (voltage: 16 bits)
  always_ff @(posedge clk) begin
    if (accept) begin
      item   <= in_data;
      now_sh <= in_data.time_now;
      cnt    <= '0;
      bat_le <= 1'b1;
      chg_le <= 1'b1;
      wd_le  <= 1'b1;
      bat_c  <= 1'b0;
      chg_c  <= 1'b0;
      wd_c   <= 1'b0;
      gt     <= 1'b0;
      lt     <= 1'b0;
      bm     <= 1'b0;
    end else if (state == bcps_pkg::ST_SCAN) begin
      cnt    <= cnt + 1'b1;
      now_sh <= now_sh >> 1;
      bat_le <= (~bd_b & n_b) | (~(bd_b ^ n_b) & bat_le);
      chg_le <= (~cd_b & n_b) | (~(cd_b ^ n_b) & chg_le);
      wd_le  <= (~wdd_b & n_b) | (~(wdd_b ^ n_b) & wd_le);
      bat_sum <= {n_b ^ bi_b ^ bat_c, bat_sum[TimeW-1:1]};
      chg_sum <= {n_b ^ ci_b ^ chg_c, chg_sum[TimeW-1:1]};
      wd_sum  <= {n_b ^ wi_b ^ wd_c, wd_sum[TimeW-1:1]};
      bat_c  <= (n_b & bi_b) | (n_b & bat_c) | (bi_b & bat_c);
      chg_c  <= (n_b & ci_b) | (n_b & chg_c) | (ci_b & chg_c);
      wd_c   <= (n_b & wi_b) | (n_b & wd_c) | (wi_b & wd_c);
      if (!cnt[4]) begin
        gt     <= (s_b & ~m_b) | (~(s_b ^ m_b) & gt);
        lt     <= (~s_b & e_b) | (~(s_b ^ e_b) & lt);
        bm     <= (~m_b & e_b) | (~(m_b ^ e_b) & bm);
        num_sh <= {s_b ^ e_b ^ lt, num_sh[VoltW-1:1]};
        spm_sh <= {m_b ^ e_b ^ bm, spm_sh[VoltW-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bcps_pkg::ST_CALC) begin
      if (lt) begin
        pct_new <= '0;
      end else begin
        pct_new <= bcps_pkg::FullPct;
      end
    end else if (div_rsp.done) begin
      pct_new <= div_rsp.quotient;
    end
  end

  bcps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bat_dl    <= '0;
      chg_dl    <= '0;
      wd_dl     <= '0;
      max_v     <= '0;
      last_pct  <= '0;
      last_stat <= '0;
      sticky    <= 1'b0;
    end else if (commit) begin
      if (bat_fire) begin
        bat_dl   <= bat_sum;
        max_v    <= new_max;
        last_pct <= pct_new;
      end
      if (chg_fire) begin
        chg_dl    <= chg_sum;
        last_stat <= code_m;
      end
      if (wd_fire) begin
        wd_dl <= wd_sum;
      end
      sticky <= res.fault_flag;
    end
  end

  // output register parts the result from the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= res;
    end
  end

  `ASSERT_NEXT(a_accept_starts_scan, clk, rst, accept,
               state == bcps_pkg::ST_SCAN && cnt == '0)
  `ASSERT_ALWAYS(a_div_done_while_waiting, clk, rst,
                 !div_rsp.done || (div_wait && state == bcps_pkg::ST_DIV_DONE))
  `ASSERT_ALWAYS(a_pct_range, clk, rst,
                 !out_valid || out_data.battery_percent <= bcps_pkg::FullPct)
  `ASSERT_ALWAYS(a_go_needs_poll, clk, rst,
                 !out_valid || !out_data.go_charging || out_data.charger_polled)

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int StuckLimit = 3000;

  logic           clk = 1'b0;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  bcps_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  bcps_pkg::out_t out_data;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [4:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  // predicted scheduler configuration and state
  logic                       cfg_bat_en;
  logic [bcps_pkg::TimeW-1:0] cfg_bat_intv;
  logic                       cfg_chg_en;
  logic [bcps_pkg::TimeW-1:0] cfg_chg_intv;
  logic [bcps_pkg::TimeW-1:0] cfg_wd_intv;
  logic [bcps_pkg::VoltW-1:0] cfg_empty;
  logic [bcps_pkg::CodeW-1:0] cfg_code_chg;
  logic [bcps_pkg::CodeW-1:0] cfg_code_con;
  logic [bcps_pkg::TimeW-1:0] bat_due;
  logic [bcps_pkg::TimeW-1:0] chg_due;
  logic [bcps_pkg::TimeW-1:0] wd_due;
  logic [bcps_pkg::VoltW-1:0] peak_v;
  logic [bcps_pkg::PctW-1:0]  pct_v;
  logic [bcps_pkg::CodeW-1:0] status_v;
  logic                       fault_v;

  bcps_pkg::out_t             poll_reports[$];
  int                         mismatch_count = 0;
  int                         stuck_cycles = 0;
  int                         stall_left = 0;
  bit                         idle_on = 1'b1;
  logic [bcps_pkg::TimeW-1:0] cur_time = '0;

  battery_charger_poll_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bcps_pkg::in_t make_tick(logic [bcps_pkg::TimeW-1:0] t,
                                              logic [bcps_pkg::VoltW-1:0] v,
                                              logic [bcps_pkg::CodeW-1:0] code,
                                              logic dock, logic clr);
    bcps_pkg::in_t r;
    r.time_now       = t;
    r.battery_sample = v;
    r.charger_code   = code;
    r.docking        = dock;
    r.clear_fault    = clr;
    return r;
  endfunction

  function automatic bcps_pkg::out_t schedule_tick(bcps_pkg::in_t t);
    bcps_pkg::out_t r;
    int unsigned    span;
    int unsigned    num;
    r = '0;
    if (t.clear_fault) fault_v = 1'b0;
    if (cfg_bat_en && bat_due <= t.time_now) begin
      r.battery_polled = 1'b1;
      bat_due = t.time_now + cfg_bat_intv;
      if (t.battery_sample > peak_v) peak_v = t.battery_sample;
      if (t.battery_sample < cfg_empty) begin
        pct_v = '0;
      end else begin
        span = 32'(peak_v) - 32'(cfg_empty);
        num  = 100 * (32'(t.battery_sample) - 32'(cfg_empty));
        pct_v = (span == 0) ? bcps_pkg::FullPct : bcps_pkg::PctW'(num / span);
      end
    end
    if (cfg_chg_en && chg_due <= t.time_now) begin
      r.charger_polled = 1'b1;
      chg_due = t.time_now + cfg_chg_intv;
      status_v = t.charger_code;
      if ((status_v & bcps_pkg::FaultMask) == bcps_pkg::FaultMask) begin
        status_v = status_v & bcps_pkg::LowMask;
        fault_v  = 1'b1;
      end
      if ((status_v == cfg_code_chg || status_v == cfg_code_con) && !t.docking)
        r.go_charging = 1'b1;
    end
    // watchdog shares the charger enable
    if (cfg_chg_en && wd_due <= t.time_now) begin
      r.watchdog_kick = 1'b1;
      wd_due = t.time_now + cfg_wd_intv;
    end
    r.battery_percent = pct_v;
    r.peak_voltage    = peak_v;
    r.charger_status  = status_v;
    r.fault_flag      = fault_v;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    bcps_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (poll_reports.size() == 0) begin
        $error("result with no request pending: %h", out_data);
        mismatch_count++;
      end else begin
        want = poll_reports.pop_front();
        check_field("battery_polled", 32'(want.battery_polled),
                    32'(out_data.battery_polled));
        check_field("battery_percent", 32'(want.battery_percent),
                    32'(out_data.battery_percent));
        check_field("peak_voltage", 32'(want.peak_voltage), 32'(out_data.peak_voltage));
        check_field("charger_polled", 32'(want.charger_polled),
                    32'(out_data.charger_polled));
        check_field("charger_status", 32'(want.charger_status),
                    32'(out_data.charger_status));
        check_field("fault_flag", 32'(want.fault_flag), 32'(out_data.fault_flag));
        check_field("go_charging", 32'(want.go_charging), 32'(out_data.go_charging));
        check_field("watchdog_kick", 32'(want.watchdog_kick),
                    32'(out_data.watchdog_kick));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // receiver stalls in random bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 17);
      end
    end
  end

  task automatic send_tick(input bcps_pkg::in_t t);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clk);
    in_valid = 1'b1;
    in_data  = t;
    do @(posedge clk); while (!in_ready);
    poll_reports.push_back(schedule_tick(t));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (poll_reports.size() != 0) @(negedge clk);
  endtask

  // write a register, then read it back
  task automatic write_reg(input bcps_pkg::reg_t r, input logic [31:0] v);
    logic [31:0] held;
    logic [31:0] got;
    case (r)
      bcps_pkg::REG_BAT_EN:   begin cfg_bat_en   = v[0];        held = {31'd0, v[0]}; end
      bcps_pkg::REG_BAT_INTV: begin cfg_bat_intv = v;           held = v; end
      bcps_pkg::REG_CHG_EN:   begin cfg_chg_en   = v[0];        held = {31'd0, v[0]}; end
      bcps_pkg::REG_CHG_INTV: begin cfg_chg_intv = v;           held = v; end
      bcps_pkg::REG_WD_INTV:  begin cfg_wd_intv  = v;           held = v; end
      bcps_pkg::REG_EMPTY:    begin cfg_empty    = v[15:0];     held = {16'd0, v[15:0]}; end
      bcps_pkg::REG_CODE_CHG: begin cfg_code_chg = v[7:0];      held = {24'd0, v[7:0]}; end
      default:                begin cfg_code_con = v[7:0];      held = {24'd0, v[7:0]}; end
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    check_field("register readback", held, got);
  endtask

  task automatic test_polls_disabled();
    send_tick(make_tick(32'd0, 16'hFFFF, 8'hF3, 1'b0, 1'b0));
    send_tick(make_tick(32'hFFFF_FFFF, 16'h0000, 8'h01, 1'b1, 1'b1));
    wait_drained();
  endtask

  // default intervals and codes after reset
  task automatic test_default_intervals();
    write_reg(bcps_pkg::REG_BAT_EN, 32'd1);
    write_reg(bcps_pkg::REG_CHG_EN, 32'd1);
    send_tick(make_tick(32'd0, 16'h1234, 8'h01, 1'b0, 1'b0));
    send_tick(make_tick(32'd999, 16'h2000, 8'h02, 1'b0, 1'b0));
    send_tick(make_tick(32'd1000, 16'h0100, 8'h02, 1'b1, 1'b0));
    wait_drained();
  endtask

  task automatic test_percent();
    write_reg(bcps_pkg::REG_CHG_EN, 32'd0);
    write_reg(bcps_pkg::REG_BAT_INTV, 32'd0);
    write_reg(bcps_pkg::REG_EMPTY, 32'h1000);
    send_tick(make_tick(32'd2000, 16'h0800, 8'h00, 1'b0, 1'b0));
    send_tick(make_tick(32'd2001, 16'h1000, 8'h00, 1'b0, 1'b0));
    send_tick(make_tick(32'd2002, 16'h1800, 8'h00, 1'b0, 1'b0));
    send_tick(make_tick(32'd2003, 16'h1400, 8'h00, 1'b0, 1'b0));
    send_tick(make_tick(32'd2004, 16'hFFFF, 8'h00, 1'b0, 1'b0));
    send_tick(make_tick(32'd2005, 16'h1000, 8'h00, 1'b0, 1'b0));
    send_tick(make_tick(32'd2006, 16'h0000, 8'h00, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_charger_codes();
    write_reg(bcps_pkg::REG_BAT_EN, 32'd0);
    write_reg(bcps_pkg::REG_CHG_EN, 32'd1);
    write_reg(bcps_pkg::REG_CHG_INTV, 32'd0);
    write_reg(bcps_pkg::REG_WD_INTV, 32'd3);
    write_reg(bcps_pkg::REG_CODE_CHG, 32'h05);
    write_reg(bcps_pkg::REG_CODE_CON, 32'h0A);
    send_tick(make_tick(32'd3000, 16'h0000, 8'hF5, 1'b0, 1'b0));
    send_tick(make_tick(32'd3001, 16'h0000, 8'h0A, 1'b1, 1'b0));
    send_tick(make_tick(32'd3002, 16'h0000, 8'h0A, 1'b0, 1'b0));
    send_tick(make_tick(32'd3003, 16'h0000, 8'h00, 1'b0, 1'b1));
    send_tick(make_tick(32'd3004, 16'h0000, 8'hFA, 1'b0, 1'b1));
    send_tick(make_tick(32'd3005, 16'h0000, 8'hFF, 1'b0, 1'b0));
    send_tick(make_tick(32'd3008, 16'h0000, 8'h50, 1'b0, 1'b0));
    wait_drained();
  endtask

  // next deadlines that pass 2^32 compare as small
  task automatic test_deadline_wrap();
    write_reg(bcps_pkg::REG_BAT_EN, 32'd1);
    write_reg(bcps_pkg::REG_BAT_INTV, 32'hFFFF_FFFF);
    write_reg(bcps_pkg::REG_CHG_INTV, 32'd10);
    write_reg(bcps_pkg::REG_WD_INTV, 32'd0);
    write_reg(bcps_pkg::REG_CODE_CHG, 32'hFF);
    write_reg(bcps_pkg::REG_CODE_CON, 32'h00);
    send_tick(make_tick(32'hFFFF_FFF8, 16'h1500, 8'h00, 1'b0, 1'b0));
    send_tick(make_tick(32'hFFFF_FFF9, 16'h1600, 8'hFF, 1'b0, 1'b0));
    send_tick(make_tick(32'hFFFF_FFFF, 16'h1700, 8'hF0, 1'b1, 1'b0));
    send_tick(make_tick(32'd0, 16'h1800, 8'h00, 1'b0, 1'b1));
    send_tick(make_tick(32'd5, 16'h1900, 8'h0F, 1'b0, 1'b0));
    wait_drained();
  endtask

  function automatic logic [31:0] pick_interval();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  function automatic logic [31:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return 32'hFF;
      1:       return $urandom_range(0, 255);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [bcps_pkg::VoltW-1:0] v;
    logic [bcps_pkg::CodeW-1:0] code;
    for (int phase = 0; phase < 12; phase++) begin
      wait_drained();
      idle_on = (phase < 10) && ($urandom_range(0, 3) != 0);
      write_reg(bcps_pkg::REG_BAT_EN, 32'($urandom_range(0, 4) != 0));
      write_reg(bcps_pkg::REG_BAT_INTV, pick_interval());
      write_reg(bcps_pkg::REG_CHG_EN, 32'($urandom_range(0, 4) != 0));
      write_reg(bcps_pkg::REG_CHG_INTV, pick_interval());
      write_reg(bcps_pkg::REG_WD_INTV, pick_interval());
      case ($urandom_range(0, 5))
        0:       write_reg(bcps_pkg::REG_EMPTY, 32'd0);
        1:       write_reg(bcps_pkg::REG_EMPTY, 32'hFFFF);
        default: write_reg(bcps_pkg::REG_EMPTY, $urandom_range(0, 65535));
      endcase
      write_reg(bcps_pkg::REG_CODE_CHG, pick_code());
      write_reg(bcps_pkg::REG_CODE_CON, pick_code());
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 199))
          0, 1, 2, 3, 4: cur_time = $urandom;
          5:             cur_time = 32'hFFFF_FFFF - $urandom_range(0, 200);
          default:       cur_time = cur_time + $urandom_range(0, 30);
        endcase
        if ($urandom_range(0, 9) < 3) v = bcps_pkg::VoltW'($urandom_range(0, 65535));
        else v = bcps_pkg::VoltW'(32'(cfg_empty) + $urandom_range(0, 4000) - 32'd1500);
        case ($urandom_range(0, 7))
          0, 1:    code = cfg_code_chg;
          2, 3:    code = cfg_code_con;
          4:       code = 8'hF0 | {4'h0, cfg_code_chg[3:0]};
          default: code = bcps_pkg::CodeW'($urandom_range(0, 255));
        endcase
        send_tick(make_tick(cur_time, v, code, 1'($urandom_range(0, 1)),
                            ($urandom_range(0, 7) == 0)));
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cfg_bat_en   = 1'b0;
    cfg_bat_intv = bcps_pkg::IntervalReset;
    cfg_chg_en   = 1'b0;
    cfg_chg_intv = bcps_pkg::IntervalReset;
    cfg_wd_intv  = bcps_pkg::IntervalReset;
    cfg_empty    = '0;
    cfg_code_chg = bcps_pkg::ChargingReset;
    cfg_code_con = bcps_pkg::ConnectReset;
    bat_due  = '0;
    chg_due  = '0;
    wd_due   = '0;
    peak_v   = '0;
    pct_v    = '0;
    status_v = '0;
    fault_v  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_polls_disabled();
    test_default_intervals();
    test_percent();
    test_charger_codes();
    test_deadline_wrap();
    test_random_traffic();

    wait_drained();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bcps_pkg.sv
sv/bcps_div.sv
sv/battery_charger_poll_scheduler.sv
tb/tb.sv
